[src/irm_pkg.sv]
// ----------------------------------------------------------------------------
// irm_pkg
// Shared types and constants for the incremental reachability matrix.
// ----------------------------------------------------------------------------
package irm_pkg;

  localparam int NODES       = 32;
  localparam int NODE_W      = 5;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // request type codes on the input channel
  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [NODES-1:0]  row_t;

  // operation decided by the front end
  typedef enum logic [1:0] {
    OP_QUERY,
    OP_ADD,
    OP_SELF,
    OP_NOP
  } op_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_CYCLE = 2'd1,
    STAT_SELF  = 2'd2
  } status_t;

  typedef struct packed {
    op_t   op;
    node_t src;
    node_t dst;
  } cmd_t;

endpackage

[src/irm_if.sv]
// ----------------------------------------------------------------------------
// irm_in_if / irm_out_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface irm_in_if import irm_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  req_type;
  node_t src_node;
  node_t dst_node;

  modport source (output valid, req_type, src_node, dst_node, input ready);
  modport sink   (input valid, req_type, src_node, dst_node, output ready);
endinterface

interface irm_out_if import irm_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        connected;

  modport source (output valid, status, connected, input ready);
  modport sink   (input valid, status, connected, output ready);
endinterface

[src/irm_front.sv]
// ----------------------------------------------------------------------------
// irm_front
// Accepts requests and classifies them into back-end commands.
// ----------------------------------------------------------------------------
module irm_front import irm_pkg::*; (
  irm_in_if.sink in_ch,
  output logic   push_valid,
  input  logic   push_ready,
  output cmd_t   push_cmd
);

  logic in_range;

  assign in_range = (32'(in_ch.src_node) < NODES) && (32'(in_ch.dst_node) < NODES);

  always_comb begin
    push_cmd.src = in_ch.src_node;
    push_cmd.dst = in_ch.dst_node;
    priority if (in_ch.req_type == REQ_QUERY) begin
      push_cmd.op = in_range ? OP_QUERY : OP_NOP;
    end else if (in_ch.src_node == in_ch.dst_node) begin
      // self loop is refused before any range check
      push_cmd.op = OP_SELF;
    end else if (in_range) begin
      push_cmd.op = OP_ADD;
    end else begin
      push_cmd.op = OP_NOP;
    end
  end

  assign push_valid  = in_ch.valid;
  assign in_ch.ready = push_ready;

endmodule

[src/irm_queue.sv]
// ----------------------------------------------------------------------------
// irm_queue
// Short command FIFO between front end and back end.
// ----------------------------------------------------------------------------
module irm_queue import irm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic q_valid,
  output cmd_t q_cmd,
  input  logic q_pop
);

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign push_ready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign q_valid    = (cnt_r != '0);
  assign q_cmd      = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[src/irm_back.sv]
// ----------------------------------------------------------------------------
// irm_back
// Holds the reachability matrix; reads one row and one column, then writes.
// ----------------------------------------------------------------------------
module irm_back import irm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  cmd_t       q_cmd,
  output logic       q_pop,
  irm_out_if.source  out_ch
);

  typedef enum logic {
    S_IDLE,
    S_APPLY
  } state_t;

  state_t  state_r, state_nxt;
  row_t    rows_r [NODES];
  row_t    rows_nxt [NODES];
  logic    out_valid_r, out_valid_nxt;
  status_t out_status_r, out_status_nxt;
  logic    out_conn_r, out_conn_nxt;

  // captured at the read step
  cmd_t    cmd_r;
  row_t    row_r;
  row_t    col_r;

  node_t   rd_addr;
  row_t    row_sel;
  row_t    col_sel;
  logic    hit;
  row_t    add_row;

  // queries read row src, adds read row dst (for the cycle check and the OR)
  assign rd_addr = (q_cmd.op == OP_QUERY) ? q_cmd.src : q_cmd.dst;
  assign row_sel = rows_r[rd_addr];

  always_comb begin
    for (int k = 0; k < NODES; k++) begin
      col_sel[k] = rows_r[k][q_cmd.src];
    end
  end

  assign q_pop   = (state_r == S_IDLE) && q_valid;
  assign hit     = row_r[(cmd_r.op == OP_QUERY) ? cmd_r.dst : cmd_r.src];
  assign add_row = row_r | (row_t'(1) << cmd_r.dst);

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_conn_nxt   = out_conn_r;
    rows_nxt       = rows_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_DONE;
          out_conn_nxt   = 1'b0;
          unique case (cmd_r.op)
            OP_QUERY: out_conn_nxt = hit;
            OP_SELF:  out_status_nxt = STAT_SELF;
            OP_ADD: begin
              if (hit) begin
                out_status_nxt = STAT_CYCLE;
              end else begin
                // row src and every row that reaches src take row dst plus dst
                for (int k = 0; k < NODES; k++) begin
                  if (col_r[k] || (NODE_W'(k) == cmd_r.src)) begin
                    rows_nxt[k] = rows_r[k] | add_row;
                  end
                end
              end
            end
            OP_NOP: ;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      out_status_r <= STAT_DONE;
      out_conn_r   <= 1'b0;
      for (int k = 0; k < NODES; k++) begin
        rows_r[k] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      out_status_r <= out_status_nxt;
      out_conn_r   <= out_conn_nxt;
      rows_r       <= rows_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_cmd;
      row_r <= row_sel;
      col_r <= col_sel;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.connected = out_conn_r;

endmodule

[src/incremental_reachability_matrix_core.sv]
// ----------------------------------------------------------------------------
// incremental_reachability_matrix_core
// Transitively closed reachability bit matrix with add-edge and query requests.
// ----------------------------------------------------------------------------
// The front end classifies each request and pushes it into a two-entry command
// queue, so requests keep being accepted while a result waits on the output.
// The back end takes one command at a time, in a read step and a write step on
// the matrix: in S_IDLE it reads row dst (row src for a query) and column src
// into registers, and in S_APPLY it applies the update to all rows in parallel
// and loads the result register, waiting there while the last result is not
// yet taken. A new command is popped only from S_IDLE. The matrix lives in
// flip-flops cleared by reset, so no clearing pass is needed.
module incremental_reachability_matrix_core import irm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  irm_in_if.sink     in_ch,
  irm_out_if.source  out_ch
);

  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  irm_front u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  irm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop)
  );

  irm_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  a_conn_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.connected) |-> (out_ch.status == STAT_DONE))
    else $error("connected result carries a refusal status");

  a_pop_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> !q_pop)
    else $error("back end took two commands in consecutive cycles");

  a_stall_means_queued: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> q_valid)
    else $error("input stalled with an empty command queue");

endmodule
